// File: sv/pli_pkg.sv
// Shared types, constants and helpers of the piecewise-linear intensity map.
package pli_pkg;

    localparam int NUM_PAIRS = 4;
    localparam int Q_DEPTH   = 4;
    localparam int NUM_W     = 40;
    localparam int DEN_W     = 32;
    localparam int Q_BITS    = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_RAW_01      = 3'd1;
    localparam logic [2:0] REG_RAW_23      = 3'd2;
    localparam logic [2:0] REG_RAW_45      = 3'd3;
    localparam logic [2:0] REG_RAW_67      = 3'd4;
    localparam logic [2:0] REG_LEVELS      = 3'd5;

    // Reset values
    localparam logic [3:0]  RST_POINT_COUNT = 4'd2;
    localparam logic [63:0] RST_RAW_01      = 64'h0000_00FF_0000_0000;
    localparam logic [63:0] RST_LEVELS      = 64'h0000_0000_0000_FF00;

    // Sample classes
    localparam logic [2:0] K_BELOW = 3'd0;
    localparam logic [2:0] K_ABOVE = 3'd1;
    localparam logic [2:0] K_WIDE  = 3'd2;
    localparam logic [2:0] K_FLAT  = 3'd3;
    localparam logic [2:0] K_NONE  = 3'd4;

    typedef struct packed {
        logic [3:0]                  point_count;
        logic [NUM_PAIRS-1:0][63:0]  raw;
        logic [63:0]                 levels;
    } t_cfg;

    typedef struct packed {
        logic              direct;
        logic [7:0]        base;
        logic              neg;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [2:0]        seg;
        logic              below;
        logic              above;
    } t_job;

    typedef struct packed {
        t_job              job;
        logic [NUM_W-1:0]  rem;
        logic [Q_BITS-1:0] q;
    } t_div;

    function automatic logic signed [31:0] f_bp(input t_cfg c, input logic [2:0] k);
        logic [63:0] pair;
        pair = c.raw[k[2:1]];
        return k[0] ? pair[63:32] : pair[31:0];
    endfunction

    function automatic logic [7:0] f_lvl(input t_cfg c, input logic [2:0] k);
        return c.levels[{k, 3'b000} +: 8];
    endfunction

endpackage

// File: sv/pli_ifs.sv
// Sample and result channel interfaces.
interface pli_smp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface pli_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_level;
    logic [2:0] segment_used;
    logic       below_range;
    logic       above_range;
    modport source (output valid, output pixel_level, output segment_used,
                    output below_range, output above_range, input ready);
    modport sink   (input valid, input pixel_level, input segment_used,
                    input below_range, input above_range, output ready);
endinterface

// File: sv/pli_front.sv
// Front end: accept samples, find the segment and form the division job.
module pli_front #(
    parameter int MAX_POINTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pli_smp_if.sink        i_smp,
    input  pli_pkg::t_cfg  i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output pli_pkg::t_job  o_job
);
    import pli_pkg::*;

    localparam int CAP = (MAX_POINTS > 8) ? 8 : MAX_POINTS;
    localparam logic [3:0] CAP_N = 4'(CAP);

    logic               adv;
    logic [3:0]         n_pts;
    logic [2:0]         last;
    logic [2:0]         n_kind;
    logic [2:0]         n_m;
    logic               wide_hit, flat_hit;
    logic [2:0]         wide_m, flat_m;
    logic signed [31:0] v;

    logic               r1_vld;
    logic signed [31:0] r1_v;
    logic [2:0]         r1_kind;
    logic [2:0]         r1_m;

    logic               r2_vld;
    t_job               r2_job;
    t_job               n_job;

    assign v   = i_smp.sample_value;
    assign adv = !r2_vld || !i_q_full;
    assign i_smp.ready = adv;
    assign o_push = adv && r2_vld;
    assign o_job  = r2_job;

    // Clamp point count and classify the sample
    always_comb begin
        n_pts = i_cfg.point_count;
        if (n_pts < 4'd2) n_pts = 4'd2;
        if (n_pts > CAP_N) n_pts = CAP_N;
        last = 3'(n_pts - 4'd1);
        wide_hit = 1'b0;
        flat_hit = 1'b0;
        wide_m   = '0;
        flat_m   = '0;
        for (int m = 0; m < 7; m++) begin
            if ((3'(m) < last) && (v >= f_bp(i_cfg, 3'(m)))
                    && (v <= f_bp(i_cfg, 3'(m + 1)))) begin
                if (f_bp(i_cfg, 3'(m + 1)) > f_bp(i_cfg, 3'(m))) begin
                    wide_hit = 1'b1;
                    wide_m   = 3'(m);
                end else begin
                    flat_hit = 1'b1;
                    flat_m   = 3'(m);
                end
            end
        end
        if (v < f_bp(i_cfg, 3'd0)) begin
            n_kind = K_BELOW;
            n_m    = '0;
        end else if (v > f_bp(i_cfg, last)) begin
            n_kind = K_ABOVE;
            n_m    = last - 3'd1;
        end else if (wide_hit) begin
            n_kind = K_WIDE;
            n_m    = wide_m;
        end else if (flat_hit) begin
            n_kind = K_FLAT;
            n_m    = flat_m;
        end else begin
            n_kind = K_NONE;
            n_m    = last - 3'd1;
        end
    end

    // Build the job from the chosen segment
    always_comb begin
        logic signed [31:0] a, b;
        logic [7:0]         la, lb;
        logic signed [8:0]  dl;
        logic [7:0]         mag;
        logic [31:0]        diff;
        a    = f_bp(i_cfg, r1_m);
        b    = f_bp(i_cfg, r1_m + 3'd1);
        la   = f_lvl(i_cfg, r1_m);
        lb   = f_lvl(i_cfg, r1_m + 3'd1);
        dl   = $signed({1'b0, lb}) - $signed({1'b0, la});
        mag  = dl[8] ? 8'(-dl) : dl[7:0];
        diff = 32'(r1_v - a);
        n_job.direct = (r1_kind != K_WIDE);
        n_job.base   = (r1_kind == K_BELOW) ? f_lvl(i_cfg, 3'd0)
                     : (r1_kind == K_WIDE) ? la : lb;
        n_job.neg    = dl[8];
        n_job.num    = NUM_W'(diff) * NUM_W'(mag);
        n_job.den    = 32'(b - a);
        n_job.seg    = r1_m;
        n_job.below  = (r1_kind == K_BELOW);
        n_job.above  = (r1_kind == K_ABOVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_smp.valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_v    <= v;
            r1_kind <= n_kind;
            r1_m    <= n_m;
            r2_job  <= n_job;
        end
    end

endmodule

// File: sv/pli_queue.sv
// Short job queue between the front end and the divider.
module pli_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pli_pkg::t_job  i_job,
    input  logic           i_pop,
    output pli_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);
    import pli_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_job          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

// File: sv/pli_back.sv
// Back end: pipelined restoring divider, floor rounding and result register.
module pli_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pli_pkg::t_job  i_job,
    input  logic           i_empty,
    output logic           o_pop,
    pli_res_if.source      o_res
);
    import pli_pkg::*;

    localparam int NST = Q_BITS + 1;

    logic       adv;
    t_div       r_st [NST];
    t_div       n_st [NST];
    logic [NST-1:0] r_v;

    logic       r_out_vld;
    logic [7:0] r_lvl;
    logic [2:0] r_seg;
    logic       r_below, r_above;
    logic [7:0] n_lvl;

    assign adv   = !r_out_vld || o_res.ready;
    assign o_pop = adv && !i_empty;

    // One quotient bit per stage, most significant first
    always_comb begin
        logic [NUM_W-1:0] trial;
        n_st[0].job = i_job;
        n_st[0].rem = i_job.num;
        n_st[0].q   = '0;
        for (int k = 0; k < Q_BITS; k++) begin
            trial = NUM_W'(r_st[k].job.den) << (Q_BITS - 1 - k);
            n_st[k+1] = r_st[k];
            if (r_st[k].rem >= trial) begin
                n_st[k+1].rem = r_st[k].rem - trial;
                n_st[k+1].q[Q_BITS-1-k] = 1'b1;
            end
        end
    end

    // Round towards minus infinity, add the left level and clamp; direct jobs take the base
    always_comb begin
        logic [8:0]        uq;
        logic signed [9:0] sum;
        uq = {1'b0, r_st[NST-1].q};
        if (r_st[NST-1].job.neg && (r_st[NST-1].rem != '0)) uq = uq + 9'd1;
        if (r_st[NST-1].job.neg)
            sum = $signed({2'b00, r_st[NST-1].job.base}) - $signed({1'b0, uq});
        else
            sum = $signed({2'b00, r_st[NST-1].job.base}) + $signed({1'b0, uq});
        if (r_st[NST-1].job.direct) n_lvl = r_st[NST-1].job.base;
        else if (sum < 0)           n_lvl = 8'd0;
        else if (sum > 10'sd255)    n_lvl = 8'd255;
        else                        n_lvl = sum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_v       <= {r_v[NST-2:0], o_pop};
            r_out_vld <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) r_st[k] <= n_st[k];
            r_lvl   <= n_lvl;
            r_seg   <= r_st[NST-1].job.seg;
            r_below <= r_st[NST-1].job.below;
            r_above <= r_st[NST-1].job.above;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.pixel_level  = r_lvl;
    assign o_res.segment_used = r_seg;
    assign o_res.below_range  = r_below;
    assign o_res.above_range  = r_above;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_below && r_above))
        else $error("sample both below and above range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_below) |-> (r_seg == 3'd0))
        else $error("below-range result with nonzero segment");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !r_st[NST-1].job.direct)
            |-> (r_st[NST-1].rem < NUM_W'(r_st[NST-1].job.den)))
        else $error("divider remainder not below divisor");

endmodule

// File: sv/piecewise_linear_intensity_map_top.sv
// Piecewise-linear intensity map: top level with configuration registers.
// Throughput: one sample per cycle while results are taken; a result stall halts
//   the divider, then fills the four-entry queue and the front, then holds the input.
// Path from sample accepted to result valid: 2 front stages, the queue,
//   9 divider stages, 1 result register.
// The divider pipeline (one quotient bit per stage) sets the latency.
// Reset (synchronous, active low) empties all stages and the queue and
//   loads the identity map: 2 points, 0..255 mapped to 0..255.
module piecewise_linear_intensity_map_top #(
    parameter int MAX_POINTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pli_smp_if.sink     i_smp,
    pli_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import pli_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_job f_job, q_job;

    // Register file: the user must write only while the datapath is idle; not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count <= RST_POINT_COUNT;
            r_cfg.raw[0]      <= RST_RAW_01;
            r_cfg.raw[1]      <= '0;
            r_cfg.raw[2]      <= '0;
            r_cfg.raw[3]      <= '0;
            r_cfg.levels      <= RST_LEVELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POINT_COUNT: r_cfg.point_count <= i_cfg_data[3:0];
                REG_RAW_01:      r_cfg.raw[0]      <= i_cfg_data;
                REG_RAW_23:      r_cfg.raw[1]      <= i_cfg_data;
                REG_RAW_45:      r_cfg.raw[2]      <= i_cfg_data;
                REG_RAW_67:      r_cfg.raw[3]      <= i_cfg_data;
                REG_LEVELS:      r_cfg.levels      <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Front end: classify the sample against the breakpoints
    pli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (f_job)
    );

    // Queue decouples front-end acceptance from result back-pressure
    pli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: interpolate and hold the result until taken
    pli_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// File: tb/tb_pli_ifs.sv
// Expected-result type shared by the testbench processes.
`timescale 1ns / 100ps
package tb_pli_types;
    typedef struct {
        logic [7:0] level;
        logic [2:0] seg;
        logic       below;
        logic       above;
    } t_pix_exp;
endpackage

// File: tb/tb_piecewise_linear_intensity_map_top.sv
// Testbench of the piecewise-linear intensity map: directed and random samples, self-checked.
`timescale 1ns / 100ps
module tb_piecewise_linear_intensity_map_top;
    import pli_pkg::*;
    import tb_pli_types::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [63:0] i_cfg_data;

    pli_smp_if smp ();
    pli_res_if res ();

    piecewise_linear_intensity_map_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp.sink), .o_res(res.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Mirror of the configuration registers
    logic [3:0]  m_count;
    logic [63:0] m_raw [4];
    logic [63:0] m_levels;

    t_pix_exp pix_queue[$];
    int err_count = 0;
    int send_idle_pct = 0;   // percentage of cycles the sender holds back
    int recv_stall_pct = 0;  // percentage of cycles the receiver stalls
    int hold_cycles = 0;     // long receiver hold-off, counted down below

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint brk(input int k);
        logic [63:0] pair;
        pair = m_raw[k >> 1];
        return (k & 1) ? longint'($signed(pair[63:32])) : longint'($signed(pair[31:0]));
    endfunction

    function automatic longint lvl_of(input int k);
        return longint'(m_levels[k*8 +: 8]);
    endfunction

    // Work out the display level, segment and range flags of one sample
    function automatic t_pix_exp map_sample(input logic signed [31:0] s);
        t_pix_exp e;
        longint v, lv, a, den, num, q;
        int n, last, wm, fm;
        bit wide, flat;
        v = longint'(s);
        n = m_count;
        if (n < 2) n = 2;
        if (n > 8) n = 8;
        last = n - 1;
        e.below = 1'b0; e.above = 1'b0;
        wide = 0; flat = 0; wm = 0; fm = 0;
        if (v < brk(0)) begin
            lv = lvl_of(0); e.seg = 3'd0; e.below = 1'b1;
        end else if (v > brk(last)) begin
            lv = lvl_of(last); e.seg = 3'(last - 1); e.above = 1'b1;
        end else begin
            for (int m = 0; m < last; m++) begin
                if (v >= brk(m) && v <= brk(m + 1)) begin
                    if (brk(m + 1) > brk(m)) begin
                        wide = 1; wm = m;
                    end else begin
                        flat = 1; fm = m;
                    end
                end
            end
            if (wide) begin
                a = brk(wm);
                den = brk(wm + 1) - a;
                num = (v - a) * (lvl_of(wm + 1) - lvl_of(wm));
                q = (num >= 0) ? num / den : -((-num + den - 1) / den);
                lv = lvl_of(wm) + q; e.seg = 3'(wm);
            end else if (flat) begin
                lv = lvl_of(fm + 1); e.seg = 3'(fm);
            end else begin
                lv = lvl_of(last); e.seg = 3'(last - 1);
            end
        end
        if (lv < 0) lv = 0;
        if (lv > 255) lv = 255;
        e.level = 8'(lv);
        return e;
    endfunction

    // Send one sample; predict at the accepting edge. Valid stays high on return,
    // so the next send or the drain decides whether to drop it.
    task automatic send_sample(input logic signed [31:0] s);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.sample_value <= s;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        pix_queue.push_back(map_sample(s));
        @(negedge i_clk);
    endtask

    // Receiver ready: random stall, or the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (pix_queue.size() == 0) begin
                report("result with nothing expected", res.pixel_level, -1);
            end else begin
                t_pix_exp e;
                e = pix_queue.pop_front();
                if (res.pixel_level !== e.level) report("pixel_level", res.pixel_level, e.level);
                if (res.segment_used !== e.seg) report("segment_used", res.segment_used, e.seg);
                if (res.below_range !== e.below) report("below_range", res.below_range, e.below);
                if (res.above_range !== e.above) report("above_range", res.above_range, e.above);
            end
        end
    end

    // Drop valid and wait for every outstanding result
    task automatic drain();
        smp.valid <= 1'b0;
        while (pix_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Write one register while idle, and mirror it (out-of-range indexes are dropped)
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT: m_count = data[3:0];
            REG_RAW_01:      m_raw[0] = data;
            REG_RAW_23:      m_raw[1] = data;
            REG_RAW_45:      m_raw[2] = data;
            REG_RAW_67:      m_raw[3] = data;
            REG_LEVELS:      m_levels = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_points(input int p[8], input logic [63:0] lv, input logic [3:0] cnt);
        write_reg(REG_POINT_COUNT, {60'd0, cnt});
        write_reg(REG_RAW_01, {p[1][31:0], p[0][31:0]});
        write_reg(REG_RAW_23, {p[3][31:0], p[2][31:0]});
        write_reg(REG_RAW_45, {p[5][31:0], p[4][31:0]});
        write_reg(REG_RAW_67, {p[7][31:0], p[6][31:0]});
        write_reg(REG_LEVELS, lv);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return brk($urandom_range(7, 0)) + $signed($urandom_range(4, 0)) - 2;
            2: return $signed($urandom_range(600, 0)) - 300;
            default: return brk($urandom_range(7, 0));
        endcase
    endfunction

    // Identity map straight after reset
    task automatic test_reset_map();
        int s[6] = '{-1, 0, 1, 128, 255, 256};
        foreach (s[i]) send_sample(s[i]);
        drain();
    endtask

    // Field extremes, flat and non-ascending segments, clamped point counts
    task automatic test_directed();
        int p[8];
        p = '{32'sh8000_0000, -1000, 0, 0, 100, 2147483647, 0, 0};
        write_points(p, 64'h00FF_01FE_8040_FF00, 4'd6);
        send_sample(32'sh8000_0000); send_sample(-1000); send_sample(-1);
        send_sample(0); send_sample(50); send_sample(100); send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh0000_FFFF); send_sample(32'sh5555_5555);
        drain();
        p = '{10, 5, 20, 20, 20, 30, 40, 50};
        write_points(p, 64'hFFEE_DDCC_BBAA_9988, 4'd0);  // clamps to two
        send_sample(7); send_sample(10); send_sample(11);
        drain();
        write_reg(REG_POINT_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);  // fifteen clamps to eight
        send_sample(20); send_sample(25); send_sample(50); send_sample(51);
        send_sample(15);
        drain();
        write_reg(3'd7, 64'h1234);  // unused index, ignored
        send_sample(45);
        drain();
    endtask

    task automatic rand_config();
        int p[8];
        int base;
        base = $signed($urandom_range(200, 0)) - 100;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(9, 0))
                0: p[i] = $urandom();
                1: p[i] = base;
                default: p[i] = base + $urandom_range(60, 0);
            endcase
            base = p[i];
        end
        if ($urandom_range(7, 0) == 0) begin
            p[0] = 32'sh8000_0000; p[7] = 32'sh7FFF_FFFF;
        end
        write_points(p, {$urandom(), $urandom()}, 4'($urandom_range(15, 0)));
    endtask

    // Random samples over several settings and idling phases
    task automatic test_random();
        int sp[4] = '{0, 65, 0, 25};
        int rp[4] = '{0, 0, 65, 25};
        for (int ph = 0; ph < 12; ph++) begin
            rand_config();
            send_idle_pct = sp[ph % 4];
            recv_stall_pct = rp[ph % 4];
            repeat (120) send_sample(rand_sample());
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
    endtask

    // Hold the receiver off while the sender keeps offering items
    task automatic test_backpressure();
        rand_config();
        hold_cycles = 80;
        repeat (100) send_sample(rand_sample());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        smp.valid = 1'b0; smp.sample_value = '0;
        res.ready = 1'b0;
        m_count = RST_POINT_COUNT;
        m_raw[0] = RST_RAW_01; m_raw[1] = '0; m_raw[2] = '0; m_raw[3] = '0;
        m_levels = RST_LEVELS;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_reset_map();
        test_directed();
        test_random();
        test_backpressure();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
